FILE: hdl/lljd_pkg.sv
// ----------------------------------------------------------------------------
// lljd_pkg
// Shared types and constants for the least-loaded job dispatcher.
// ----------------------------------------------------------------------------
package lljd_pkg;

  localparam int MAX_COUNTERS = 16;
  localparam int MAX_SLOTS    = 256;
  localparam int CTR_W        = $clog2(MAX_COUNTERS);
  localparam int NUM_W        = 5;
  localparam int SLOT_W       = $clog2(MAX_SLOTS);
  localparam int LOAD_W       = 32;
  localparam int JOB_W        = 16;
  localparam int WAIT_W       = 48;
  localparam int OUT_W        = 128;

  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(MAX_SLOTS - 1);

  // candidate handed from cell to cell during the minimum scan
  typedef struct packed {
    logic              run;
    logic              has;
    logic [LOAD_W-1:0] load;
    logic [SLOT_W-1:0] cnt;
    logic [CTR_W-1:0]  idx;
  } lljd_tok_t;

  // write-back command broadcast to the cells
  typedef struct packed {
    logic              clear;
    logic              wr;
    logic [CTR_W-1:0]  idx;
    logic [LOAD_W-1:0] load;
    logic [SLOT_W-1:0] cnt;
  } lljd_cmd_t;

endpackage

FILE: hdl/lljd_cell.sv
// ----------------------------------------------------------------------------
// lljd_cell
// One counter: holds its load and job count, and passes the running
// minimum candidate on to the next cell.
// ----------------------------------------------------------------------------
module lljd_cell
  import lljd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CTR_W-1:0] cell_idx,
  input  logic             active,
  input  lljd_cmd_t        cmd,
  input  lljd_tok_t        tok_in,
  output lljd_tok_t        tok_out
);

  logic [LOAD_W-1:0] load_r, load_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  lljd_tok_t         tok_r, tok_nxt;
  logic              take;

  assign take = active && (!tok_in.has || (load_r < tok_in.load));

  always_comb begin
    load_nxt = load_r;
    cnt_nxt  = cnt_r;
    if (cmd.clear) begin
      load_nxt = '0;
      cnt_nxt  = '0;
    end else if (cmd.wr && (cmd.idx == cell_idx)) begin
      load_nxt = cmd.load;
      cnt_nxt  = cmd.cnt;
    end
  end

  always_comb begin
    tok_nxt     = tok_in;
    tok_nxt.run = tok_in.run;
    if (tok_in.run && take) begin
      tok_nxt.has  = 1'b1;
      tok_nxt.load = load_r;
      tok_nxt.cnt  = cnt_r;
      tok_nxt.idx  = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
      cnt_r  <= '0;
      tok_r  <= '0;
    end else begin
      load_r <= load_nxt;
      cnt_r  <= cnt_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: hdl/least_loaded_job_dispatch.sv
// ----------------------------------------------------------------------------
// least_loaded_job_dispatch
// Greedy list scheduler: places each job on the least loaded counter.
// ----------------------------------------------------------------------------
// Input channel in_*: one job per transaction, job_time in in_tdata and the
// first-of-batch flag in in_tuser. A set flag clears all loads, job counts,
// the peak load, the waiting total and the saturation flag before the
// job is placed.
// Result channel out_*: one transaction per job with the chosen counter,
// its slot, the start time, the peak load, the waiting total and the
// sticky saturation flag.
// Configuration: cfg_we writes cfg_wdata into num_counters (0 acts as 1,
// values above 16 act as 16). Write only while the block is idle.
// Timing: the minimum search is a row of 16 cells; the candidate moves one
// cell per cycle. A job passes through ST_LAUNCH, ST_SCAN and ST_UPDATE,
// and no new job is accepted before the block is back in ST_IDLE.
// in_tready is high only while no job is in work.
// A finished result sits in an output register; the next job is accepted
// and scanned while it waits, and its write-back holds until the register
// frees. Reset sets num_counters to 1 and clears all but the data registers.
// ----------------------------------------------------------------------------
module least_loaded_job_dispatch
  import lljd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [NUM_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [JOB_W-1:0] in_tdata,   // [15:0] job_time
  input  logic             in_tuser,   // [0] first_of_batch
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [3:0] assigned_counter, [11:4] slot_on_counter,
                                       // [43:12] start_time, [75:44] peak_load,
                                       // [123:76] total_waiting, [124] saturated
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  act_cnt;
  logic [JOB_W-1:0]  job_r;
  logic [CTR_W-1:0]  best_idx_r;
  logic [LOAD_W-1:0] best_load_r;
  logic [SLOT_W-1:0] best_cnt_r;
  logic [LOAD_W-1:0] max_r, max_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic              sat_r, sat_nxt;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic              in_acc;
  logic              upd_go;
  logic [LOAD_W:0]   load_sum;
  logic [LOAD_W-1:0] new_load;
  logic [SLOT_W-1:0] new_cnt;
  logic [WAIT_W:0]   wait_sum;
  lljd_cmd_t         cmd;
  lljd_tok_t         tok [MAX_COUNTERS+1];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign upd_go    = (state_r == ST_UPDATE) && (!out_valid_r || out_tready);

  always_comb begin
    if (num_r == '0) begin
      act_cnt = NUM_W'(1);
    end else if (num_r > NUM_W'(MAX_COUNTERS)) begin
      act_cnt = NUM_W'(MAX_COUNTERS);
    end else begin
      act_cnt = num_r;
    end
  end

  always_comb begin
    tok[0]      = '0;
    tok[0].run  = (state_r == ST_LAUNCH);
  end

  for (genvar g = 0; g < MAX_COUNTERS; g++) begin : g_cell
    lljd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (CTR_W'(g)),
      .active   (NUM_W'(g) < act_cnt),
      .cmd      (cmd),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  assign load_sum = {1'b0, best_load_r} + {{(LOAD_W+1-JOB_W){1'b0}}, job_r};
  assign new_load = load_sum[LOAD_W] ? '1 : load_sum[LOAD_W-1:0];
  assign new_cnt  = (best_cnt_r == SLOT_MAX) ? SLOT_MAX : best_cnt_r + SLOT_W'(1);
  assign wait_sum = {1'b0, wait_r} + {{(WAIT_W+1-LOAD_W){1'b0}}, best_load_r};

  always_comb begin
    cmd       = '0;
    cmd.clear = in_acc && in_tuser;
    cmd.wr    = upd_go;
    cmd.idx   = best_idx_r;
    cmd.load  = new_load;
    cmd.cnt   = new_cnt;
  end

  always_comb begin
    max_nxt  = max_r;
    wait_nxt = wait_r;
    sat_nxt  = sat_r;
    if (cmd.clear) begin
      max_nxt  = '0;
      wait_nxt = '0;
      sat_nxt  = 1'b0;
    end else if (upd_go) begin
      max_nxt  = (new_load > max_r) ? new_load : max_r;
      wait_nxt = wait_sum[WAIT_W] ? '1 : wait_sum[WAIT_W-1:0];
      sat_nxt  = sat_r || load_sum[LOAD_W] || wait_sum[WAIT_W] ||
                 (best_cnt_r == SLOT_MAX);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_SCAN;
      ST_SCAN:   if (tok[MAX_COUNTERS].run) state_nxt = ST_UPDATE;
      ST_UPDATE: if (upd_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_r       <= NUM_W'(1);
      max_r       <= '0;
      wait_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      max_r   <= max_nxt;
      wait_r  <= wait_nxt;
      sat_r   <= sat_nxt;
      if (cfg_we) begin
        num_r <= cfg_wdata;
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      job_r <= in_tdata;
    end
    if ((state_r == ST_SCAN) && tok[MAX_COUNTERS].run) begin
      best_idx_r  <= tok[MAX_COUNTERS].idx;
      best_load_r <= tok[MAX_COUNTERS].load;
      best_cnt_r  <= tok[MAX_COUNTERS].cnt;
    end
    if (upd_go) begin
      out_data_r <= {3'b000, sat_nxt, wait_nxt, max_nxt, best_load_r,
                     best_cnt_r, best_idx_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
